@@ design/assert_macros.svh @@
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent, outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent, reset included.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/stm_pkg.sv @@
package stm_pkg;

   // Depth of the template store.
   localparam int TEMPLATE_ELEMENTS = 1024;
   localparam int ADDR_W = (TEMPLATE_ELEMENTS > 1) ? $clog2(TEMPLATE_ELEMENTS) : 1;

   // Width of a widened compare against the depth.
   localparam int CMP_W = 17;

   typedef enum logic [1:0] {
      FMT_U8  = 2'd0,
      FMT_S8  = 2'd1,
      FMT_U16 = 2'd2,
      FMT_S16 = 2'd3
   } format_type;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_WINDOW = 1'b1
   } opcode_type;

   // Turn raw sample bits into a 17-bit signed value under the given format.
   function automatic logic signed [16:0] decode_sample(input logic [15:0] raw,
                                                       input format_type fmt);
      logic signed [16:0] value;
      case (fmt)
         FMT_U8:  value = {9'd0, raw[7:0]};
         FMT_S8:  value = {{9{raw[7]}}, raw[7:0]};
         FMT_U16: value = {1'b0, raw};
         FMT_S16: value = {raw[15], raw};
         default: value = {1'b0, raw};
      endcase
      return value;
   endfunction

endpackage

@@ design/ssd_template_match.sv @@
// Sum-of-squared-differences template matcher for one band.
// Request channel (req_*): opcode 0 loads sample_raw into the template store
// at position; opcode 1 is a window sample that is compared against the stored
// template sample at position. The squared difference adds into a 32-bit sum
// that wraps; a window request with last_of_window set emits the sum on the
// response channel (rsp_*) and clears it. csr_write_data sets the sample format
// (unsigned/signed, 8/16 bit) when csr_write_enable is high.
// After the edge that accepts the last window request, the response goes through
// the template memory read, then subtract and square, then accumulate into the
// output register before it is valid.
// Throughput: one request per cycle unless stalled; after a window request marked
// last, the request side stalls until that sum reaches the output register.
// The response sits in an output register; while it waits under rsp_stall the
// request side stalls as well.
// Reset clears the running sum, the pipeline, the response valid and the
// format (unsigned 8-bit). The template store is not cleared: load each
// position before a window request reads it.
// When rsp_stall is high with a response waiting, rsp_distance holds and the pending sum blocks requests.
module ssd_template_match (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [9:0]  req_position,
   input  logic [15:0] req_sample_raw,
   input  logic        req_last_of_window,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_distance,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data
);

   logic [15:0] template_mem [stm_pkg::TEMPLATE_ELEMENTS];

   stm_pkg::format_type format_ff;
   logic                req_accept;
   logic                req_in_range;
   logic                is_window;
   logic [stm_pkg::ADDR_W-1:0] mem_addr;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_last_ff;
   logic        s1_in_range_ff;
   logic [15:0] s1_raw_ff;
   logic [15:0] rd_data_ff;

   logic        s2_valid_ff, s2_valid_in;
   logic        s2_last_ff;
   logic [31:0] sq_ff, sq_in;

   logic [31:0] sum_ff, sum_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_distance_ff;
   logic        emit;

   logic [15:0]        tmpl_bits;
   logic signed [16:0] tmpl_val;
   logic signed [16:0] img_val;
   logic signed [17:0] diff;
   logic [17:0]        diff_abs;
   logic [16:0]        mag;
   logic [33:0]        sq_full;

   // Hold requests while a sum is in flight or the output is blocked.
   assign req_stall  = (rsp_valid_ff && rsp_stall) || (s1_valid_ff && s1_last_ff)
                    || (s2_valid_ff && s2_last_ff);
   assign req_accept = req_valid && !req_stall;
   assign is_window  = (stm_pkg::opcode_type'(req_opcode) == stm_pkg::OP_WINDOW);
   assign req_in_range = (stm_pkg::CMP_W'(req_position)
                          < stm_pkg::CMP_W'(stm_pkg::TEMPLATE_ELEMENTS));
   assign mem_addr = stm_pkg::ADDR_W'(req_position);

   // Format register.
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= stm_pkg::FMT_U8;
      end else if (csr_write_enable) begin
         format_ff <= stm_pkg::format_type'(csr_write_data);
      end
   end

   // Template memory: write on load, registered read on window.
   always_ff @(posedge clock) begin
      if (req_accept && !is_window && req_in_range) begin
         template_mem[mem_addr] <= req_sample_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && is_window && req_in_range) begin
         rd_data_ff <= template_mem[mem_addr];
      end
   end

   // Stage 1: carry the window sample alongside the memory read.
   assign s1_valid_in = req_accept && is_window;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_valid_in && req_last_of_window;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_raw_ff      <= req_sample_raw;
         s1_in_range_ff <= req_in_range;
      end
   end

   // Decode, subtract and square.
   always_comb begin
      tmpl_bits = s1_in_range_ff ? rd_data_ff : 16'd0;
      tmpl_val  = stm_pkg::decode_sample(tmpl_bits, format_ff);
      img_val   = stm_pkg::decode_sample(s1_raw_ff, format_ff);
      diff      = {tmpl_val[16], tmpl_val} - {img_val[16], img_val};
      diff_abs  = diff[17] ? (18'd0 - diff) : diff;
      mag       = diff_abs[16:0];
      sq_full   = mag * mag;
      sq_in     = sq_full[31:0];
   end

   // Stage 2: register the square.
   assign s2_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_last_ff  <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s2_last_ff  <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_in) begin
         sq_ff <= sq_in;
      end
   end

   // Accumulate; emit and clear on the last sample.
   assign sum_in = sum_ff + sq_ff;
   assign emit   = s2_valid_ff && s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= 32'd0;
      end else if (emit) begin
         sum_ff <= 32'd0;
      end else if (s2_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

   // Output register: load on emit, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_distance_ff <= sum_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

endmodule

@@ design/stm_checker.sv @@
`include "assert_macros.svh"

module stm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_opcode,
   input logic        req_last_of_window,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_distance
);

   logic rsp_held;
   logic last_take;

   // A response waiting under stall, and a taken request that closes a window.
   assign rsp_held  = rsp_valid && rsp_stall;
   assign last_take = req_valid && !req_stall && req_opcode && req_last_of_window;

   // A stalled response stays up and holds its value.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid, "response dropped")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_held, $stable(rsp_distance), "response changed")

   // Reset leaves no response pending.
   `ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid, "response valid after reset")

   // A last window request blocks the next request while its sum is in flight.
   `ASSERT_NEXT(a_last_interlock, clock, reset, last_take, req_stall, "request behind pending sum")

   // No response rises in the cycle right after a last window request.
   `ASSERT_NEXT(a_no_early_rsp, clock, reset, last_take && !rsp_valid, !rsp_valid, "response too early")

endmodule

bind ssd_template_match stm_checker u_stm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_opcode         (req_opcode),
   .req_last_of_window (req_last_of_window),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_distance       (rsp_distance)
);

@@ tb/sv/tb.sv @@
module tb;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CHUNK_REQUESTS   = 134;
   localparam int DIRECTED_ROWS    = 15;

   // One row of the directed table; distance is only trusted when known is set.
   typedef struct packed {
      stm_pkg::format_type fmt;
      stm_pkg::opcode_type op;
      logic [9:0]          pos;
      logic [15:0]         raw;
      logic                last;
      logic                known;
      logic [31:0]         distance;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = 1'b0;
   logic [9:0]  req_position = 10'd0;
   logic [15:0] req_sample_raw = 16'd0;
   logic        req_last_of_window = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_distance;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_write_data = 2'd0;

   // Local copy of the block state for prediction.
   logic [15:0]         template_copy [stm_pkg::TEMPLATE_ELEMENTS];
   logic [31:0]         sum_copy = 32'd0;
   stm_pkg::format_type format_copy = stm_pkg::FMT_U8;

   logic [31:0] pending_distances [$];
   bit          loaded [stm_pkg::TEMPLATE_ELEMENTS];
   int          loaded_list [$];

   int          errors = 0;
   int unsigned cycle_count = 0;
   int          req_idle_pct = 28;
   int          rsp_idle_pct = 87;
   logic        hold_armed = 1'b0;
   logic        hold_taken = 1'b0;
   int          hold_left = 0;
   logic [31:0] want_distance;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{stm_pkg::FMT_U8,  stm_pkg::OP_LOAD,   10'd0,    16'hFFFF, 1'b1, 1'b0, 32'd0},
      '{stm_pkg::FMT_U8,  stm_pkg::OP_LOAD,   10'd1023, 16'h0000, 1'b0, 1'b0, 32'd0},
      '{stm_pkg::FMT_U8,  stm_pkg::OP_WINDOW, 10'd0,    16'h0000, 1'b1, 1'b1, 32'd65025},
      '{stm_pkg::FMT_U8,  stm_pkg::OP_WINDOW, 10'd1023, 16'hFF00, 1'b1, 1'b1, 32'd0},
      '{stm_pkg::FMT_S8,  stm_pkg::OP_WINDOW, 10'd0,    16'h007F, 1'b1, 1'b1, 32'd16384},
      '{stm_pkg::FMT_S8,  stm_pkg::OP_WINDOW, 10'd1023, 16'h0080, 1'b1, 1'b1, 32'd16384},
      '{stm_pkg::FMT_U16, stm_pkg::OP_WINDOW, 10'd0,    16'h0000, 1'b1, 1'b1, 32'hFFFE0001},
      '{stm_pkg::FMT_S16, stm_pkg::OP_LOAD,   10'd2,    16'h7FFF, 1'b0, 1'b0, 32'd0},
      '{stm_pkg::FMT_S16, stm_pkg::OP_LOAD,   10'd3,    16'h8000, 1'b1, 1'b0, 32'd0},
      '{stm_pkg::FMT_S16, stm_pkg::OP_WINDOW, 10'd2,    16'h8000, 1'b0, 1'b0, 32'd0},
      '{stm_pkg::FMT_S16, stm_pkg::OP_WINDOW, 10'd3,    16'h7FFF, 1'b1, 1'b1, 32'hFFFC0002},
      '{stm_pkg::FMT_S16, stm_pkg::OP_WINDOW, 10'd0,    16'h0000, 1'b0, 1'b0, 32'd0},
      '{stm_pkg::FMT_S16, stm_pkg::OP_WINDOW, 10'd1023, 16'h0001, 1'b1, 1'b1, 32'd2},
      '{stm_pkg::FMT_U8,  stm_pkg::OP_WINDOW, 10'd2,    16'h12FF, 1'b1, 1'b1, 32'd0},
      '{stm_pkg::FMT_U8,  stm_pkg::OP_WINDOW, 10'd3,    16'h1234, 1'b1, 1'b0, 32'd0}
   };

   ssd_template_match uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_sample_raw     (req_sample_raw),
      .req_last_of_window (req_last_of_window),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_distance       (rsp_distance),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #4 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** ssd_template_match: FAILED **");
         $finish;
      end
   end

   // Response side: one long hold-off when armed, random stalls otherwise.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_taken) begin
         rsp_stall  <= 1'b1;
         hold_left  <= LONG_HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Compare each accepted distance with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_distances.size() == 0) begin
            $display("%0t: unexpected distance, expected none, actual %0d",
                     $time, rsp_distance);
            errors++;
         end else begin
            want_distance = pending_distances.pop_front();
            if (rsp_distance !== want_distance) begin
               $display("%0t: distance mismatch, expected %0d, actual %0d",
                        $time, want_distance, rsp_distance);
               errors++;
            end
         end
      end
   end

   // Read stored or incoming bits as a signed value under the given format.
   function automatic int sample_value(logic [15:0] bits, stm_pkg::format_type fmt);
      int v;
      if (fmt == stm_pkg::FMT_U8 || fmt == stm_pkg::FMT_S8) begin
         v = int'(bits[7:0]);
         if (fmt == stm_pkg::FMT_S8 && bits[7]) v -= 256;
      end else begin
         v = int'(bits);
         if (fmt == stm_pkg::FMT_S16 && bits[15]) v -= 65536;
      end
      return v;
   endfunction

   // Advance the local state by one request; return 1 when a distance comes out.
   function automatic bit accumulate_request(stm_pkg::opcode_type op, logic [9:0] pos,
                                             logic [15:0] raw, logic last,
                                             output logic [31:0] distance);
      longint diff;
      distance = 32'd0;
      if (op == stm_pkg::OP_LOAD) begin
         template_copy[pos] = raw;
         return 1'b0;
      end
      diff = longint'(sample_value(template_copy[pos], format_copy))
           - longint'(sample_value(raw, format_copy));
      sum_copy = sum_copy + 32'(diff * diff);
      if (!last) return 1'b0;
      distance = sum_copy;
      sum_copy = 32'd0;
      return 1'b1;
   endfunction

   // Offer one request, wait for acceptance, then record its prediction.
   task automatic push_request(stm_pkg::opcode_type op, logic [9:0] pos,
                               logic [15:0] raw, logic last, logic known,
                               logic [31:0] known_distance);
      logic [31:0] predicted;
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_position       <= pos;
      req_sample_raw     <= raw;
      req_last_of_window <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == stm_pkg::OP_LOAD && !loaded[pos]) begin
         loaded[pos] = 1'b1;
         loaded_list.push_back(int'(pos));
      end
      if (accumulate_request(op, pos, raw, last, predicted))
         pending_distances.push_back(known ? known_distance : predicted);
   endtask

   // Wait until every predicted distance has arrived and the pipeline is empty.
   task automatic wait_quiet();
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_format(stm_pkg::format_type fmt);
      csr_write_enable <= 1'b1;
      csr_write_data   <= fmt;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      format_copy = fmt;
   endtask

   function automatic logic [15:0] random_sample();
      case ($urandom_range(11))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h7FFF;
         3: return 16'h8000;
         4: return 16'h00FF;
         5: return 16'h0080;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [9:0] random_position();
      case ($urandom_range(15))
         0: return 10'd0;
         1: return 10'd1023;
         default: return 10'($urandom_range(1023));
      endcase
   endfunction

   // Mostly complete windows over loaded positions, with stray loads and
   // windows that lose their last mark and run into the next one.
   task automatic random_chunk(int count);
      int sent;
      int run_len;
      logic [9:0] pos;
      sent = 0;
      while (sent < count) begin
         if (loaded_list.size() == 0 || $urandom_range(99) < 20) begin
            push_request(stm_pkg::OP_LOAD, random_position(), random_sample(),
                         1'($urandom_range(1)), 1'b0, 32'd0);
            sent++;
         end else begin
            run_len = $urandom_range(1, 12);
            for (int k = 0; k < run_len; k++) begin
               if ($urandom_range(9) == 0) begin
                  push_request(stm_pkg::OP_LOAD, random_position(), random_sample(),
                               1'($urandom_range(1)), 1'b0, 32'd0);
                  sent++;
               end
               pos = 10'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
               push_request(stm_pkg::OP_WINDOW, pos, random_sample(),
                            (k == run_len - 1) && ($urandom_range(9) != 0),
                            1'b0, 32'd0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < stm_pkg::TEMPLATE_ELEMENTS; i++) template_copy[i] = 16'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: change format only once the block has gone quiet.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].fmt != format_copy) begin
            req_valid <= 1'b0;
            wait_quiet();
            set_format(directed_rows[r].fmt);
         end
         push_request(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].raw,
                      directed_rows[r].last, directed_rows[r].known,
                      directed_rows[r].distance);
      end

      // Random part: three idling modes, every format in each.
      for (int mode = 0; mode < 3; mode++) begin
         for (int k = 0; k < 4; k++) begin
            req_valid <= 1'b0;
            wait_quiet();
            set_format(stm_pkg::format_type'(2'((k + mode) % 4)));
            case (mode)
               0: begin
                  req_idle_pct = 28;
                  rsp_idle_pct <= 87;
               end
               1: begin
                  req_idle_pct = 87;
                  rsp_idle_pct <= 28;
               end
               default: begin
                  req_idle_pct = 0;
                  rsp_idle_pct <= 0;
               end
            endcase
            // Back up the response side once while requests keep coming.
            if (mode == 2 && k == 0) hold_armed <= 1'b1;
            random_chunk(CHUNK_REQUESTS);
         end
      end

      req_valid <= 1'b0;
      wait_quiet();
      if (errors == 0)
         $display("** ssd_template_match: PASSED **");
      else
         $display("** ssd_template_match: FAILED **");
      $finish;
   end

endmodule
